// ===== hw/rtl/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_READ  = 2'd2,
        OP_SET   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } t_state;

    localparam logic [13:0] FREE_CAP  = 14'd8192;
    localparam logic [7:0]  FULL_BYTE = 8'hff;

    // Position of the lowest clear bit; zero when the byte is full.
    function automatic logic [2:0] low_zero_bit(input logic [7:0] b);
        logic [2:0] k;
        begin
            k = 3'd0;
            priority casez (b)
                8'b???????0: k = 3'd0;
                8'b??????01: k = 3'd1;
                8'b?????011: k = 3'd2;
                8'b????0111: k = 3'd3;
                8'b???01111: k = 3'd4;
                8'b??011111: k = 3'd5;
                8'b?0111111: k = 3'd6;
                8'b01111111: k = 3'd7;
                default:     k = 3'd0;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bfa_ram.sv =====
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_first_free_allocator_unit.sv =====
`default_nettype none
// Channel   Direction  Handshake            Word
// ------    ---------  -------------------  ----------------------------------------
// command   in         i_start & !o_busy    i_opcode, i_byte_index, i_value
// result    out        o_done (one cycle)   o_alloc_index, o_found, o_read_byte,
//                                           o_free_left
// config    in         i_cfg_we             i_cfg_wdata (bytes in use)
//
// Load, set and a refused allocate give their result in the cycle after the command.
// A read passes through ST_READ, waiting on the registered read port of the bitmap memory.
// An allocate walks the bitmap one byte per cycle through the single memory read port,
// from byte 0 up to byte min(bytes_in_use, MAX_BYTES)-1, stopping at the first clear bit.
// Reset clears the free counter and sets bytes in use to 1024; the bitmap is not cleared.
// The receiver cannot stall; each result word is shown for exactly one cycle.

module bitmap_first_free_allocator_unit #(
    parameter int MAX_BYTES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [9:0]  i_byte_index,
    input  wire logic [13:0] i_value,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_wdata,
    output logic             o_done,
    output logic [12:0]      o_alloc_index,
    output logic             o_found,
    output logic [7:0]       o_read_byte,
    output logic [13:0]      o_free_left
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [12:0] MAX_N = 13'(MAX_BYTES);

    bfa_pkg::t_state r_state, n_state;
    logic [13:0]     r_free, n_free;
    logic [10:0]     r_biu;
    logic [AW-1:0]   r_chk, n_chk;
    logic            r_rdok, n_rdok;
    logic            r_done, n_done;
    logic [12:0]     r_alloc, n_alloc;
    logic            r_found, n_found;
    logic [7:0]      r_rbyte, n_rbyte;
    logic [13:0]     r_fleft, n_fleft;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    logic            accept;
    logic [12:0]     idx_w;
    logic            in_range;
    logic [12:0]     scan_n;
    logic            last;
    logic [2:0]      zbit;
    logic [13:0]     set_val;

    bfa_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept   = i_start && !o_busy;
    assign idx_w    = 13'(i_byte_index);
    assign in_range = idx_w < MAX_N;
    assign scan_n   = ({2'b00, r_biu} > MAX_N) ? MAX_N : {2'b00, r_biu};
    assign last     = (13'(r_chk) + 13'd1) == scan_n;
    assign zbit     = bfa_pkg::low_zero_bit(ram_rdata);
    assign set_val  = (i_value > bfa_pkg::FREE_CAP) ? bfa_pkg::FREE_CAP : i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfa_pkg::ST_IDLE;
            r_free  <= 14'd0;
            r_biu   <= 11'd1024;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_biu <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk   <= n_chk;
        r_rdok  <= n_rdok;
        r_alloc <= n_alloc;
        r_found <= n_found;
        r_rbyte <= n_rbyte;
        r_fleft <= n_fleft;
    end

    always_comb begin
        n_state   = r_state;
        n_free    = r_free;
        n_chk     = r_chk;
        n_rdok    = r_rdok;
        n_done    = 1'b0;
        n_alloc   = r_alloc;
        n_found   = r_found;
        n_rbyte   = r_rbyte;
        n_fleft   = r_fleft;
        ram_we    = 1'b0;
        ram_waddr = idx_w[AW-1:0];
        ram_wdata = i_value[7:0];
        ram_raddr = r_chk + AW'(1);

        unique case (r_state)
            bfa_pkg::ST_IDLE: begin
                if (accept) begin
                    n_alloc = 13'd0;
                    n_found = 1'b0;
                    n_rbyte = 8'd0;
                    n_fleft = r_free;
                    unique case (bfa_pkg::t_opcode'(i_opcode))
                        bfa_pkg::OP_LOAD: begin
                            ram_we = in_range;
                            n_done = 1'b1;
                        end
                        bfa_pkg::OP_READ: begin
                            ram_raddr = idx_w[AW-1:0];
                            n_rdok    = in_range;
                            n_state   = bfa_pkg::ST_READ;
                        end
                        bfa_pkg::OP_SET: begin
                            n_free  = set_val;
                            n_fleft = set_val;
                            n_done  = 1'b1;
                        end
                        bfa_pkg::OP_ALLOC: begin
                            if (r_free == 14'd0 || scan_n == 13'd0) begin
                                n_done = 1'b1;
                            end else begin
                                ram_raddr = '0;
                                n_chk     = '0;
                                n_state   = bfa_pkg::ST_SCAN;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            bfa_pkg::ST_READ: begin
                n_rbyte = r_rdok ? ram_rdata : 8'd0;
                n_done  = 1'b1;
                n_state = bfa_pkg::ST_IDLE;
            end
            bfa_pkg::ST_SCAN: begin
                if (ram_rdata != bfa_pkg::FULL_BYTE) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk;
                    ram_wdata = ram_rdata | (8'd1 << zbit);
                    n_free    = r_free - 14'd1;
                    n_fleft   = r_free - 14'd1;
                    n_alloc   = 13'({r_chk, zbit});
                    n_found   = 1'b1;
                    n_done    = 1'b1;
                    n_state   = bfa_pkg::ST_IDLE;
                end else if (last) begin
                    n_done  = 1'b1;
                    n_state = bfa_pkg::ST_IDLE;
                end else begin
                    n_chk = r_chk + AW'(1);
                end
            end
            default: n_state = bfa_pkg::ST_IDLE;
        endcase
    end

    assign o_busy        = r_state != bfa_pkg::ST_IDLE;
    assign o_done        = r_done;
    assign o_alloc_index = r_alloc;
    assign o_found       = r_found;
    assign o_read_byte   = r_rbyte;
    assign o_free_left   = r_fleft;

    a_found_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_read_byte == 8'd0))
        else $error("allocation result carries read data");

    a_found_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_free_left == $past(r_free) - 14'd1))
        else $error("free counter not decremented by one on allocation");

    a_scan_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfa_pkg::ST_SCAN) |-> (r_free != 14'd0))
        else $error("scan running with an empty free counter");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted command neither busy nor answered");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;

    localparam int MAP_BYTES = 1024;

    typedef struct packed {
        logic [12:0] slot;
        logic        hit;
        logic [7:0]  byte_out;
        logic [13:0] left;
    } t_alloc_word;

    // Mirrors the bitmap and free counter, and holds the words still to come.
    class t_bitmap_book;
        bit [7:0]    bitmap [MAP_BYTES];
        bit          loaded [MAP_BYTES];
        bit [13:0]   free_slots;
        bit [10:0]   span = 11'd1024;
        t_alloc_word awaited [$];
        int          errors;

        function int scan_len();
            return (span > MAP_BYTES) ? MAP_BYTES : int'(span);
        endfunction

        // An allocate must not scan a byte that has never been loaded.
        function bit alloc_is_safe();
            int i;
            if (free_slots == 0) begin
                return 1;
            end
            for (i = 0; i < scan_len(); i++) begin
                if (!loaded[i]) begin
                    return 0;
                end
                if (bitmap[i] != bfa_pkg::FULL_BYTE) begin
                    return 1;
                end
            end
            return 1;
        endfunction

        function void note_command(bfa_pkg::t_opcode op, logic [9:0] idx, logic [13:0] val);
            t_alloc_word w;
            int          i;
            int          k;
            w = '0;
            case (op)
                bfa_pkg::OP_LOAD: begin
                    bitmap[idx] = val[7:0];
                    loaded[idx] = 1'b1;
                end
                bfa_pkg::OP_READ: begin
                    w.byte_out = bitmap[idx];
                end
                bfa_pkg::OP_SET: begin
                    free_slots = (val > bfa_pkg::FREE_CAP) ? bfa_pkg::FREE_CAP : val;
                end
                default: begin
                    if (free_slots != 0) begin
                        for (i = 0; i < scan_len(); i++) begin
                            if (bitmap[i] != bfa_pkg::FULL_BYTE) begin
                                for (k = 0; k < 8; k++) begin
                                    if (!bitmap[i][k]) begin
                                        break;
                                    end
                                end
                                bitmap[i][k] = 1'b1;
                                free_slots--;
                                w.slot = 13'(i * 8 + k);
                                w.hit = 1'b1;
                                break;
                            end
                        end
                    end
                end
            endcase
            w.left = free_slots;
            awaited.push_back(w);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t: %s", $time, what);
        endtask

        task check_word(t_alloc_word got);
            t_alloc_word want;
            if (awaited.size() == 0) begin
                report_mismatch("result word arrived with nothing outstanding");
            end else begin
                want = awaited.pop_front();
                if (got.slot !== want.slot) begin
                    report_mismatch($sformatf("alloc_index %0d, wanted %0d",
                                              got.slot, want.slot));
                end
                if (got.hit !== want.hit) begin
                    report_mismatch($sformatf("found %0b, wanted %0b", got.hit, want.hit));
                end
                if (got.byte_out !== want.byte_out) begin
                    report_mismatch($sformatf("read_byte %02h, wanted %02h",
                                              got.byte_out, want.byte_out));
                end
                if (got.left !== want.left) begin
                    report_mismatch($sformatf("free_left %0d, wanted %0d",
                                              got.left, want.left));
                end
            end
        endtask

        task close_out();
            while (awaited.size() != 0) begin
                void'(awaited.pop_front());
                report_mismatch("result word never arrived");
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_opcode;
    logic [9:0]  i_byte_index;
    logic [13:0] i_value;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;
    logic        o_done;
    logic [12:0] o_alloc_index;
    logic        o_found;
    logic [7:0]  o_read_byte;
    logic [13:0] o_free_left;

    t_bitmap_book book = new();
    int           items_sent;
    int           idle_pct;
    int           phase_no;
    int           idle_modes [4] = '{0, 66, 0, 21};

    bitmap_first_free_allocator_unit #(
        .MAX_BYTES(MAP_BYTES)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy(o_busy),
        .i_opcode(i_opcode),
        .i_byte_index(i_byte_index),
        .i_value(i_value),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done),
        .o_alloc_index(o_alloc_index),
        .o_found(o_found),
        .o_read_byte(o_read_byte),
        .o_free_left(o_free_left)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            book.check_word({o_alloc_index, o_found, o_read_byte, o_free_left});
        end
    end

    task automatic issue(bfa_pkg::t_opcode op, logic [9:0] idx, logic [13:0] val);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
        @(negedge i_clk);
        i_start = 1'b1;
        i_opcode = op;
        i_byte_index = idx;
        i_value = val;
        do @(posedge i_clk); while (o_busy);
        book.note_command(op, idx, val);
        items_sent++;
    endtask

    task automatic set_span(int v);
        @(negedge i_clk);
        i_start = 1'b0;
        while (book.awaited.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = 11'(v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        book.span = 11'(v);
    endtask

    function automatic logic [13:0] map_word(int full_pct);
        logic [5:0] hi;
        logic [7:0] b;
        hi = ($urandom_range(3) == 0) ? 6'($urandom) : 6'd0;
        if ($urandom_range(99) < full_pct) begin
            b = bfa_pkg::FULL_BYTE;
        end else if ($urandom_range(1) == 1) begin
            b = ~(8'd1 << $urandom_range(7));
        end else begin
            b = 8'($urandom);
        end
        return {hi, b};
    endfunction

    task automatic load_set_alloc_read();
        int win;
        int fill;
        int i;
        int idx;
        win = book.scan_len();
        if (win == 0) begin
            win = 8;
        end
        fill = (win > 64) ? 95 : 50;
        for (i = 0; i < win; i++) begin
            if (!book.loaded[i]) begin
                issue(bfa_pkg::OP_LOAD, 10'(i), map_word(fill));
            end
        end
        repeat ($urandom_range(1, 3)) begin
            issue(bfa_pkg::OP_LOAD, 10'($urandom_range(win - 1)), map_word(fill));
        end
        if ($urandom_range(3) != 0) begin
            issue(bfa_pkg::OP_SET, 10'($urandom),
                  ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(12)));
        end
        repeat ($urandom_range(1, 6)) begin
            if (book.alloc_is_safe()) begin
                issue(bfa_pkg::OP_ALLOC, 10'($urandom), 14'($urandom));
            end
        end
        repeat ($urandom_range(0, 2)) begin
            idx = $urandom_range(win - 1);
            if (book.loaded[idx]) begin
                issue(bfa_pkg::OP_READ, 10'(idx), 14'($urandom));
            end
        end
    endtask

    task automatic stray_command();
        logic [9:0] idx;
        idx = 10'($urandom);
        case ($urandom_range(3))
            0: issue(bfa_pkg::OP_LOAD, idx, 14'($urandom));
            1: issue(bfa_pkg::OP_SET, idx, 14'($urandom));
            2: begin
                if (book.loaded[idx]) begin
                    issue(bfa_pkg::OP_READ, idx, 14'($urandom));
                end else begin
                    issue(bfa_pkg::OP_LOAD, idx, 14'($urandom));
                end
            end
            default: begin
                if (book.alloc_is_safe()) begin
                    issue(bfa_pkg::OP_ALLOC, idx, 14'($urandom));
                end else begin
                    issue(bfa_pkg::OP_SET, idx, 14'($urandom_range(20)));
                end
            end
        endcase
    endtask

    task automatic run_phase(int span_v, int quota);
        int first;
        set_span(span_v);
        idle_pct = idle_modes[phase_no % 4];
        phase_no++;
        first = items_sent;
        while (items_sent - first < quota) begin
            if ($urandom_range(99) < 70) begin
                load_set_alloc_read();
            end else begin
                stray_command();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_opcode = bfa_pkg::OP_LOAD;
        i_byte_index = '0;
        i_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        idle_pct = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_span(4);
        issue(bfa_pkg::OP_ALLOC, 10'd0, 14'd0);
        issue(bfa_pkg::OP_LOAD, 10'd0, 14'h00fe);
        issue(bfa_pkg::OP_LOAD, 10'd1, 14'h3fff);
        issue(bfa_pkg::OP_LOAD, 10'd2, 14'h2a7f);
        issue(bfa_pkg::OP_LOAD, 10'd3, 14'h0080);
        issue(bfa_pkg::OP_LOAD, 10'd1023, 14'h0055);
        issue(bfa_pkg::OP_SET, 10'd0, 14'd16383);
        issue(bfa_pkg::OP_SET, 10'd0, 14'd8193);
        issue(bfa_pkg::OP_SET, 10'd0, 14'd8192);
        issue(bfa_pkg::OP_SET, 10'd0, 14'd3);
        repeat (4) issue(bfa_pkg::OP_ALLOC, 10'd0, 14'd0);
        issue(bfa_pkg::OP_SET, 10'd0, 14'd5);
        issue(bfa_pkg::OP_LOAD, 10'd3, 14'h00ff);
        issue(bfa_pkg::OP_ALLOC, 10'd0, 14'd0);
        issue(bfa_pkg::OP_READ, 10'd0, 14'd0);
        issue(bfa_pkg::OP_READ, 10'd1, 14'd0);
        issue(bfa_pkg::OP_READ, 10'd2, 14'd0);
        issue(bfa_pkg::OP_READ, 10'd3, 14'd0);
        issue(bfa_pkg::OP_READ, 10'd1023, 14'd0);
        set_span(0);
        issue(bfa_pkg::OP_ALLOC, 10'd0, 14'd0);

        run_phase(1, 100);
        run_phase(8, 120);
        run_phase(3, 100);
        run_phase(0, 40);
        run_phase(16, 120);
        run_phase(64, 100);
        run_phase(128, 100);

        set_span(2047);
        idle_pct = 0;
        issue(bfa_pkg::OP_SET, 10'd0, 14'd8192);
        issue(bfa_pkg::OP_LOAD, 10'd127, {6'($urandom), ~(8'd1 << $urandom_range(7))});
        if (book.alloc_is_safe()) begin
            issue(bfa_pkg::OP_ALLOC, 10'd0, 14'd0);
        end
        issue(bfa_pkg::OP_READ, 10'd127, 14'd0);

        run_phase(5, 100);

        @(negedge i_clk);
        i_start = 1'b0;
        while (book.awaited.size() != 0) @(negedge i_clk);
        repeat (16) @(posedge i_clk);
        book.close_out();
        if (book.errors == 0) begin
            $display("bitmap_first_free_allocator_unit: match");
        end else begin
            $display("bitmap_first_free_allocator_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("bitmap_first_free_allocator_unit: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_ram.sv
hw/rtl/bitmap_first_free_allocator_unit.sv
test/tb_top.sv
